// ===== sv/dtt_pkg.sv =====
// ----------------------------------------------------------------------------
// dtt_pkg: shared types and constants of the detection track table
// Item formats, table entry layout, item kinds and sequencer states.
// ----------------------------------------------------------------------------
package dtt_pkg;

    localparam int MAX_TRACKS = 16;
    localparam int IDX_W      = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int CNT_W      = $clog2(MAX_TRACKS + 1);

    localparam int MIN_HITS_RESET = 15;
    localparam logic [7:0] HITS_MAX = 8'hFF;

    typedef enum logic [1:0] {
        KIND_DETECT = 2'd0,
        KIND_EOF    = 2'd1,
        KIND_LOST   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRAP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] rect_x;
        logic [11:0] rect_y;
        logic [11:0] rect_w;
        logic [11:0] rect_h;
    } dtt_in_t;

    typedef struct packed {
        logic        matched;
        logic [3:0]  slot;
        logic        dropped;
        logic        lock;
        logic [11:0] lock_x;
        logic [11:0] lock_y;
        logic [11:0] lock_w;
        logic [11:0] lock_h;
        logic [4:0]  live_entries;
    } dtt_out_t;

    typedef struct packed {
        logic [11:0] left;
        logic [11:0] top;
        logic [11:0] width;
        logic [11:0] height;
        logic [7:0]  hits;
        logic        fresh;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic write;
    } cell_ctrl_t;

endpackage

// ===== sv/dtt_cell.sv =====
// ----------------------------------------------------------------------------
// dtt_cell: one table entry
// Holds one rectangle with its hit count and update mark. It either takes
// the entry of its upper neighbor, loads a written entry, or holds.
// ----------------------------------------------------------------------------
module dtt_cell
    import dtt_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  entry_t     nbr,
    input  entry_t     wdata,
    output entry_t     ent
);

    entry_t ent_reg;
    entry_t ent_next;

    // A write lands on a place already vacated by the shift, so it wins.
    always_comb
    begin
        ent_next = ent_reg;
        if (ctrl.write)
        begin
            ent_next = wdata;
        end
        else if (ctrl.shift)
        begin
            ent_next = nbr;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign ent = ent_reg;

endmodule

// ===== sv/dtt_match.sv =====
// ----------------------------------------------------------------------------
// dtt_match: detection against entry test
// Center strictly inside the entry, and each size ratio at least 3/4.
// ----------------------------------------------------------------------------
module dtt_match
    import dtt_pkg::*;
(
    input  entry_t  ent,
    input  dtt_in_t det,
    output logic    fit
);

    logic [13:0] cx;
    logic [13:0] cy;
    logic [13:0] x_lo;
    logic [13:0] x_hi;
    logic [13:0] y_lo;
    logic [13:0] y_hi;
    logic [11:0] w_min;
    logic [11:0] w_max;
    logic [11:0] h_min;
    logic [11:0] h_max;
    logic        center_in;
    logic        w_ok;
    logic        h_ok;

    always_comb
    begin
        cx   = {1'b0, det.rect_x, 1'b0} + {2'b00, det.rect_w};
        cy   = {1'b0, det.rect_y, 1'b0} + {2'b00, det.rect_h};
        x_lo = {1'b0, ent.left, 1'b0};
        y_lo = {1'b0, ent.top, 1'b0};
        x_hi = {({1'b0, ent.left} + {1'b0, ent.width}), 1'b0};
        y_hi = {({1'b0, ent.top} + {1'b0, ent.height}), 1'b0};
        center_in = (cx > x_lo) && (cx < x_hi) && (cy > y_lo) && (cy < y_hi);

        w_min = (det.rect_w < ent.width) ? det.rect_w : ent.width;
        w_max = (det.rect_w < ent.width) ? ent.width : det.rect_w;
        h_min = (det.rect_h < ent.height) ? det.rect_h : ent.height;
        h_max = (det.rect_h < ent.height) ? ent.height : det.rect_h;

        // 4*min against 3*max, with 3*max written as 2*max + max.
        w_ok = {w_min, 2'b00} >= ({1'b0, w_max, 1'b0} + {2'b00, w_max});
        h_ok = {h_min, 2'b00} >= ({1'b0, h_max, 1'b0} + {2'b00, h_max});

        fit = center_in && w_ok && h_ok;
    end

endmodule

// ===== sv/detection_track_table.sv =====
// ----------------------------------------------------------------------------
// detection_track_table: ordered table of candidate rectangles
// Each accepted item is handled up to its result before the next is taken:
// detections and ends of frame in detection mode pass through SCAN, WRAP
// and DONE; other items go through WRAP and DONE and skip the scan. The
// scan moves the entry row past its head cell once, one entry a cycle, and
// a stalled result holds off the next item.
// Reset: empty table, detection mode, min_hits 15; no clearing pass.
// ----------------------------------------------------------------------------
module detection_track_table
    import dtt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  dtt_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output dtt_out_t out_data,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic [7:0] cfg_data
);

    state_t             state_reg;
    state_t             state_next;
    dtt_in_t            op_reg;
    dtt_in_t            op_next;
    logic [CNT_W-1:0]   k_reg;
    logic [CNT_W-1:0]   k_next;
    logic [CNT_W-1:0]   c_reg;
    logic [CNT_W-1:0]   c_next;
    logic [CNT_W-1:0]   total_reg;
    logic [CNT_W-1:0]   total_next;
    logic [CNT_W-1:0]   hit_slot_reg;
    logic [CNT_W-1:0]   hit_slot_next;
    logic               hit_reg;
    logic               hit_next;
    logic               lock_found_reg;
    logic               lock_found_next;
    entry_t             lock_ent_reg;
    entry_t             lock_ent_next;
    logic               locked_reg;
    logic               locked_next;
    logic [7:0]         min_hits_reg;
    dtt_out_t           res_reg;
    dtt_out_t           res_next;
    dtt_out_t           out_reg;
    logic               out_valid_reg;

    entry_t             cell_ent   [MAX_TRACKS];
    cell_ctrl_t         cell_ctrl  [MAX_TRACKS];
    entry_t             wdata;
    entry_t             head;
    entry_t             head_upd;
    entry_t             new_ent;
    logic               fit_raw;
    logic               fit_now;
    logic               in_accept;
    logic               scan_step;
    logic               is_detect;
    logic               is_eof;
    logic               room;
    logic               keep;
    logic               append;
    logic               out_load;
    logic [CNT_W-1:0]   wpos;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign head      = cell_ent[0];
    assign is_detect = (op_reg.kind == KIND_DETECT);
    assign is_eof    = (op_reg.kind == KIND_EOF);
    assign scan_step = (state_reg == ST_SCAN) && (k_reg != total_reg);
    assign room      = (total_reg < CNT_W'(MAX_TRACKS));
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    assign fit_now   = fit_raw && !hit_reg;
    assign append    = (state_reg == ST_WRAP) && is_detect && !locked_reg
                       && !hit_reg && room;

    dtt_match u_match
    (
        .ent (head),
        .det (op_reg),
        .fit (fit_raw)
    );

    always_comb
    begin
        head_upd       = head;
        head_upd.left  = op_reg.rect_x;
        head_upd.top   = op_reg.rect_y;
        head_upd.width = op_reg.rect_w;
        head_upd.height = op_reg.rect_h;
        head_upd.fresh = 1'b1;
        if (head.hits != HITS_MAX)
        begin
            head_upd.hits = head.hits + 8'd1;
        end

        new_ent.left   = op_reg.rect_x;
        new_ent.top    = op_reg.rect_y;
        new_ent.width  = op_reg.rect_w;
        new_ent.height = op_reg.rect_h;
        new_ent.hits   = 8'd1;
        new_ent.fresh  = 1'b1;
    end

    // The head entry goes back in behind the entries kept so far; with
    // remaining entries shifted down, that place is total - k - 1 + c.
    always_comb
    begin
        keep  = is_detect || head.fresh;
        wpos  = total_reg - k_reg - CNT_W'(1) + c_reg;
        wdata = head;
        if (state_reg == ST_WRAP)
        begin
            wdata = new_ent;
            wpos  = total_reg;
        end
        else if (is_detect)
        begin
            if (fit_now)
            begin
                wdata = head_upd;
            end
        end
        else
        begin
            wdata.fresh = 1'b0;
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_TRACKS; g++)
        begin : g_cell
            entry_t nbr;

            if (g == MAX_TRACKS - 1)
            begin : g_last
                assign nbr = cell_ent[0];
            end
            else
            begin : g_mid
                assign nbr = cell_ent[g + 1];
            end

            assign cell_ctrl[g].shift = scan_step;
            assign cell_ctrl[g].write =
                ((scan_step && keep) || append)
                && (wpos[IDX_W-1:0] == IDX_W'(g));

            dtt_cell u_cell
            (
                .clk   (clk),
                .ctrl  (cell_ctrl[g]),
                .nbr   (nbr),
                .wdata (wdata),
                .ent   (cell_ent[g])
            );
        end
    endgenerate

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if ((in_data.kind == KIND_DETECT || in_data.kind == KIND_EOF)
                        && !locked_reg)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_WRAP;
                    end
                end
            end
            ST_SCAN:
            begin
                if (k_reg == total_reg)
                begin
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer registers and result.
    always_comb
    begin
        op_next         = op_reg;
        k_next          = k_reg;
        c_next          = c_reg;
        total_next      = total_reg;
        hit_next        = hit_reg;
        hit_slot_next   = hit_slot_reg;
        lock_found_next = lock_found_reg;
        lock_ent_next   = lock_ent_reg;
        locked_next     = locked_reg;
        res_next        = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next         = in_data;
                    k_next          = '0;
                    c_next          = '0;
                    hit_next        = 1'b0;
                    lock_found_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (scan_step)
                begin
                    k_next = k_reg + CNT_W'(1);
                    if (keep)
                    begin
                        c_next = c_reg + CNT_W'(1);
                    end
                    if (is_detect)
                    begin
                        if (fit_now)
                        begin
                            hit_next      = 1'b1;
                            hit_slot_next = k_reg;
                        end
                    end
                    else if (head.fresh)
                    begin
                        // Scanning upward, the last candidate is the newest.
                        if (head.hits > min_hits_reg)
                        begin
                            lock_found_next = 1'b1;
                            lock_ent_next   = head;
                        end
                    end
                end
            end
            ST_WRAP:
            begin
                res_next = '0;
                case (op_reg.kind)
                    KIND_LOST:
                    begin
                        total_next  = '0;
                        locked_next = 1'b0;
                    end
                    KIND_DETECT:
                    begin
                        if (!locked_reg)
                        begin
                            if (hit_reg)
                            begin
                                res_next.matched = 1'b1;
                                res_next.slot    = 4'(hit_slot_reg);
                            end
                            else if (room)
                            begin
                                res_next.slot = 4'(total_reg);
                                total_next    = total_reg + CNT_W'(1);
                            end
                            else
                            begin
                                res_next.dropped = 1'b1;
                            end
                        end
                    end
                    KIND_EOF:
                    begin
                        if (!locked_reg)
                        begin
                            if (lock_found_reg)
                            begin
                                locked_next     = 1'b1;
                                total_next      = '0;
                                res_next.lock   = 1'b1;
                                res_next.lock_x = lock_ent_reg.left;
                                res_next.lock_y = lock_ent_reg.top;
                                res_next.lock_w = lock_ent_reg.width;
                                res_next.lock_h = lock_ent_reg.height;
                            end
                            else
                            begin
                                total_next = c_reg;
                            end
                        end
                    end
                    default:
                    begin
                        total_next = total_reg;
                    end
                endcase
                res_next.live_entries = 5'(total_next);
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            locked_reg    <= 1'b0;
            min_hits_reg  <= 8'(MIN_HITS_RESET);
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            c_reg         <= '0;
            hit_reg       <= 1'b0;
            lock_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            total_reg      <= total_next;
            locked_reg     <= locked_next;
            k_reg          <= k_next;
            c_reg          <= c_next;
            hit_reg        <= hit_next;
            lock_found_reg <= lock_found_next;
            if (cfg_valid && cfg_ready)
            begin
                min_hits_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        hit_slot_reg <= hit_slot_next;
        lock_ent_reg <= lock_ent_next;
        res_reg      <= res_next;
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

endmodule

// ===== bench/dtt_track_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dtt_track_check: prediction and comparison for the detection track table
// Watches the input, result and min_hits channels, keeps its own copy of the
// track table, works out the result of every accepted item and compares each
// accepted result field by field with the oldest one outstanding.
// ----------------------------------------------------------------------------
module dtt_track_check
    import dtt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  dtt_in_t    in_data,
    input  logic       out_valid,
    input  logic       out_stall,
    input  dtt_out_t   out_data,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [7:0] cfg_data,
    output int         fail_count,
    output int         pending,
    output int         update_count,
    output int         drop_count,
    output int         lock_count
);

    entry_t     track_tab [MAX_TRACKS];
    int         track_total;
    logic       locked;
    logic [7:0] min_hits;
    dtt_out_t   outcome_q [$];
    dtt_out_t   want;
    int         mismatches;
    int         updates;
    int         drops;
    int         locks;

    function automatic bit ratio_ok(int a, int b);
        int lo;
        int hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return 4 * lo >= 3 * hi;
    endfunction

    // Centers are compared at twice the scale so that no halving is needed.
    function automatic bit rect_fits(entry_t e, dtt_in_t d);
        int cx;
        int cy;
        cx = 2 * int'(d.rect_x) + int'(d.rect_w);
        cy = 2 * int'(d.rect_y) + int'(d.rect_h);
        if (cx <= 2 * int'(e.left) || cx >= 2 * (int'(e.left) + int'(e.width)))
            return 1'b0;
        if (cy <= 2 * int'(e.top) || cy >= 2 * (int'(e.top) + int'(e.height)))
            return 1'b0;
        return ratio_ok(int'(d.rect_w), int'(e.width))
               && ratio_ok(int'(d.rect_h), int'(e.height));
    endfunction

    function automatic void place_rect(int i, dtt_in_t d);
        track_tab[i].left   = d.rect_x;
        track_tab[i].top    = d.rect_y;
        track_tab[i].width  = d.rect_w;
        track_tab[i].height = d.rect_h;
        track_tab[i].fresh  = 1'b1;
    endfunction

    function automatic dtt_out_t track_step(dtt_in_t d);
        dtt_out_t r;
        int       i;
        int       j;
        int       k;
        bit       hit;
        r   = '0;
        hit = 1'b0;
        if (d.kind == KIND_LOST) begin
            track_total = 0;
            locked      = 1'b0;
        end
        else if (d.kind == KIND_DETECT && !locked) begin
            for (i = 0; i < track_total; i++) begin
                if (rect_fits(track_tab[i], d)) begin
                    place_rect(i, d);
                    if (track_tab[i].hits != HITS_MAX)
                        track_tab[i].hits++;
                    r.matched = 1'b1;
                    r.slot    = i[3:0];
                    hit       = 1'b1;
                    break;
                end
            end
            if (!hit) begin
                if (track_total < MAX_TRACKS) begin
                    place_rect(track_total, d);
                    track_tab[track_total].hits = 8'd1;
                    r.slot = track_total[3:0];
                    track_total++;
                end
                else begin
                    r.dropped = 1'b1;
                end
            end
        end
        else if (d.kind == KIND_EOF && !locked) begin
            // Newest first: stale entries are squeezed out, the first ripe one locks.
            for (j = track_total; j > 0; j--) begin
                i = j - 1;
                if (!track_tab[i].fresh) begin
                    for (k = i; k + 1 < track_total; k++)
                        track_tab[k] = track_tab[k + 1];
                    track_total--;
                end
                else if (track_tab[i].hits > min_hits) begin
                    locked   = 1'b1;
                    r.lock   = 1'b1;
                    r.lock_x = track_tab[i].left;
                    r.lock_y = track_tab[i].top;
                    r.lock_w = track_tab[i].width;
                    r.lock_h = track_tab[i].height;
                    track_total = 0;
                    break;
                end
            end
            for (i = 0; i < track_total; i++)
                track_tab[i].fresh = 1'b0;
        end
        r.live_entries = track_total[4:0];
        return r;
    endfunction

    task automatic check_field(string name, int unsigned exp_val, int unsigned got_val);
        if (exp_val != got_val) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, got_val);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            track_total = 0;
            locked      = 1'b0;
            min_hits    = 8'(MIN_HITS_RESET);
            outcome_q.delete();
            mismatches  = 0;
            updates     = 0;
            drops       = 0;
            locks       = 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (outcome_q.size() == 0) begin
                    $display("%0t ns: result with no item outstanding, expected none, actual %h",
                             $time, out_data);
                    mismatches++;
                end
                else begin
                    want = outcome_q.pop_front();
                    check_field("matched", want.matched, out_data.matched);
                    check_field("slot", want.slot, out_data.slot);
                    check_field("dropped", want.dropped, out_data.dropped);
                    check_field("lock", want.lock, out_data.lock);
                    check_field("lock_x", want.lock_x, out_data.lock_x);
                    check_field("lock_y", want.lock_y, out_data.lock_y);
                    check_field("lock_w", want.lock_w, out_data.lock_w);
                    check_field("lock_h", want.lock_h, out_data.lock_h);
                    check_field("live_entries", want.live_entries, out_data.live_entries);
                    updates += want.matched;
                    drops   += want.dropped;
                    locks   += want.lock;
                end
            end
            if (in_valid && !in_stall)
                outcome_q.insert(outcome_q.size(), track_step(in_data));
            if (cfg_valid && cfg_ready)
                min_hits = cfg_data;
        end
        fail_count   <= mismatches;
        pending      <= outcome_q.size();
        update_count <= updates;
        drop_count   <= drops;
        lock_count   <= locks;
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the detection track table
// Drives directed items, then tracked scenes of jittered boxes, table floods
// and noise under several min_hits settings and idling patterns, and reports
// the verdict from the failure count of the checking module.
// ----------------------------------------------------------------------------
module tb_top;
    import dtt_pkg::*;

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int PRESSURE_PHASE = 5;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 40;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    dtt_in_t    in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    dtt_out_t   out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data  = 8'd0;

    int fail_count;
    int pending;
    int update_count;
    int drop_count;
    int lock_count;

    int idle_pct      = 0;
    int stall_pct     = 0;
    int phase_no      = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    int cycle_count   = 0;
    int items_sent    = 0;
    int settings_used = 1;
    int cur_min_hits  = MIN_HITS_RESET;

    detection_track_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    dtt_track_check track_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .update_count (update_count),
        .drop_count   (drop_count),
        .lock_count   (lock_count)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side. In the pressure phase it holds off once for a long stretch
    // so that the block backs up into its input.
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (phase_no == PRESSURE_PHASE && !hold_done) begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    function automatic logic [11:0] to_field(int v);
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[11:0];
    endfunction

    function automatic int pick_size();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
            return $urandom_range(8, 300);
        else if (roll < 8)
            return $urandom_range(300, 4095);
        else
            return $urandom_range(1, 8);
    endfunction

    function automatic int jitter(int pos, int size);
        int d;
        d = size / 8;
        return pos + int'($urandom_range(0, 2 * d)) - d;
    endfunction

    function automatic int wobble(int size);
        int d;
        d = size / 16;
        return size + int'($urandom_range(0, 2 * d)) - d;
    endfunction

    function automatic dtt_in_t random_item(logic [1:0] k);
        dtt_in_t it;
        it.kind   = k;
        it.rect_x = 12'($urandom_range(0, 4095));
        it.rect_y = 12'($urandom_range(0, 4095));
        it.rect_w = 12'($urandom_range(0, 4095));
        it.rect_h = 12'($urandom_range(0, 4095));
        return it;
    endfunction

    // Valid is only lowered at the start of a gap, never in the step that
    // raises it for the next item.
    task automatic drive_item(dtt_in_t it);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic send_det(int x, int y, int w, int h);
        dtt_in_t it;
        it.kind   = KIND_DETECT;
        it.rect_x = to_field(x);
        it.rect_y = to_field(y);
        it.rect_w = to_field(w);
        it.rect_h = to_field(h);
        drive_item(it);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic set_min_hits(int v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v[7:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_min_hits = v;
        settings_used++;
    endtask

    task automatic set_phase(int n, int idle, int stall);
        phase_no  <= n;
        stall_pct <= stall;
        idle_pct  = idle;
    endtask

    task automatic run_random(int budget);
        int stop;
        int choice;
        int n_obj;
        int frames;
        int f;
        int o;
        int reps;
        int r;
        int n;
        int k;
        int ox [4];
        int oy [4];
        int ow [4];
        int oh [4];
        stop = items_sent + budget;
        while (items_sent < stop) begin
            choice = $urandom_range(0, 99);
            if (choice < 70) begin
                // A few objects seen frame after frame, now and then missed or
                // seen twice, with stray boxes mixed in.
                n_obj = $urandom_range(1, 4);
                for (o = 0; o < n_obj; o++) begin
                    ow[o] = pick_size();
                    oh[o] = pick_size();
                    ox[o] = $urandom_range(0, 4095);
                    oy[o] = $urandom_range(0, 4095);
                end
                frames = $urandom_range(1, (cur_min_hits + 4 < 24) ? cur_min_hits + 4 : 24);
                for (f = 0; f < frames; f++) begin
                    for (o = 0; o < n_obj; o++) begin
                        reps = ($urandom_range(0, 19) == 0) ? 0 :
                               ($urandom_range(0, 9) == 0) ? 2 : 1;
                        for (r = 0; r < reps; r++)
                            send_det(jitter(ox[o], ow[o]), jitter(oy[o], oh[o]),
                                     wobble(ow[o]), wobble(oh[o]));
                    end
                    if ($urandom_range(0, 3) == 0)
                        drive_item(random_item(KIND_DETECT));
                    if ($urandom_range(0, 49) == 0)
                        drive_item(random_item(KIND_SPARE));
                    drive_item(random_item(KIND_EOF));
                end
                if ($urandom_range(0, 9) < 7)
                    drive_item(random_item(KIND_LOST));
            end
            else if (choice < 82) begin
                // Small scattered boxes rarely match, so the table runs out of room.
                n = $urandom_range(17, 22);
                for (k = 0; k < n; k++)
                    send_det($urandom_range(0, 4095), $urandom_range(0, 4095),
                             $urandom_range(1, 64), $urandom_range(1, 64));
                drive_item(random_item(KIND_EOF));
            end
            else begin
                n = $urandom_range(1, 6);
                for (k = 0; k < n; k++)
                    drive_item(random_item(2'($urandom_range(0, 3))));
            end
        end
    endtask

    initial begin
        int i;
        int bx;
        int by;
        int bw;
        int bh;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_phase(0, 0, 0);
        send_det(4095, 4095, 4095, 4095);
        send_det(4095, 4095, 4095, 4095);
        send_det(0, 0, 1, 1);
        send_det(0, 0, 0, 0);
        send_det(100, 100, 400, 400);
        // Exactly at the three-quarter size ratio, then just below it.
        send_det(150, 150, 300, 300);
        send_det(200, 200, 224, 300);
        drive_item(random_item(KIND_SPARE));
        drive_item(random_item(KIND_EOF));
        send_det(150, 150, 300, 300);
        for (i = 0; i < 11; i++)
            send_det(1000 + 200 * i, 3000, 100, 100);
        send_det(2000, 2000, 50, 50);
        drive_item(random_item(KIND_EOF));
        drive_item(random_item(KIND_LOST));

        set_phase(1, 0, 0);
        run_random(250);

        set_min_hits(0);
        set_phase(2, 63, 0);
        run_random(200);

        // One rectangle hit far past the point where its count saturates.
        set_min_hits(254);
        set_phase(3, 0, 63);
        bw = pick_size();
        bh = pick_size();
        bx = $urandom_range(0, 4095);
        by = $urandom_range(0, 4095);
        drive_item(random_item(KIND_LOST));
        for (i = 0; i < 270; i++)
            send_det(bx, by, bw, bh);
        drive_item(random_item(KIND_EOF));
        drive_item(random_item(KIND_LOST));
        run_random(100);

        set_min_hits(3);
        set_phase(4, 17, 17);
        run_random(250);

        set_min_hits($urandom_range(1, 40));
        set_phase(PRESSURE_PHASE, 0, 0);
        run_random(200);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Drove %0d items over %0d min_hits settings, with a saturating hit burst",
                 items_sent, settings_used);
        $display("and a long output hold-off: %0d updates, %0d drops, %0d locks expected.",
                 update_count, drop_count, lock_count);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== detection_track_table.f =====
sv/dtt_pkg.sv
sv/dtt_cell.sv
sv/dtt_match.sv
sv/detection_track_table.sv
bench/dtt_track_check.sv
bench/tb_top.sv
